// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and held off during rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

// ===== rtl/actss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actss_pkg
// constants and types shared by the actigraphy sleep scorer
// ----------------------------------------------------------------------------
package actss_pkg;

  localparam int unsigned DATA_W            = 16;
  localparam int unsigned CNT_W             = 6;
  localparam int unsigned WARM_W            = 4;
  localparam int unsigned SAMPLES_PER_EPOCH = 14;
  localparam int unsigned WARMUP_EPOCHS     = 5;
  localparam int unsigned HIST_DEPTH        = 5;

  // weighted total e0 + 5e1 + 25e2 + 5e3 + e4 stays within +/- 37 * 2^15
  localparam int unsigned TOTAL_W = 22;
  localparam int unsigned MAG_W   = 21;

  // divide by 25: floor(m * RECIP / 2^RECIP_SHIFT) is exact for m < 2^MAG_W
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2684355);

  localparam logic [DATA_W-1:0] COUNT_MAX = '1;
  localparam logic [DATA_W-1:0] POS_LIMIT = DATA_W'(32767);
  localparam logic [DATA_W-1:0] NEG_LIMIT = DATA_W'(32768);

  typedef struct packed {
    logic [DATA_W-1:0] epoch_sum;
    logic              neg;
    logic [MAG_W-1:0]  mag;
  } actss_token_t;

endpackage

// ===== rtl/actss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actss_if
// sample, result and configuration channels of the sleep scorer
// ----------------------------------------------------------------------------
interface actss_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface actss_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] epoch_sum;
  logic signed [15:0] activity;
  logic               below_threshold;
  logic        [15:0] sleep_minutes;

  modport source (output valid, output epoch_sum, output activity,
                  output below_threshold, output sleep_minutes, input ready);
  modport sink (input valid, input epoch_sum, input activity,
                input below_threshold, input sleep_minutes, output ready);
endinterface

interface actss_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sleep_threshold;

  modport source (output valid, output sleep_threshold, input ready);
  modport sink (input valid, input sleep_threshold, output ready);
endinterface

// ===== rtl/actss_epoch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actss_epoch
// epoch accumulation, history shift and weighted five-epoch total
// ----------------------------------------------------------------------------
module actss_epoch import actss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  actss_sample_if.sink  in_smp,
  output logic          tok_valid,
  input  logic          tok_ready,
  output actss_token_t  tok
);

  logic [DATA_W-1:0] acc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WARM_W-1:0] warm_r;
  logic [DATA_W-1:0] hist_r [HIST_DEPTH];
  logic              s1_v_r;
  logic              s2_v_r;
  actss_token_t      s2_tok_r;

  logic               ld2;
  logic               accept;
  logic               last;
  logic               warm_done;
  logic [DATA_W-1:0]  sum_new;
  logic signed [TOTAL_W-1:0] e [HIST_DEPTH];
  logic signed [TOTAL_W-1:0] pair_out;
  logic signed [TOTAL_W-1:0] pair_in;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] total_abs;

  // a scoring epoch waits in s1 until s2 frees, so the history stays put meanwhile
  assign ld2          = !s2_v_r || tok_ready;
  assign in_smp.ready = !s1_v_r || ld2;
  assign accept       = in_smp.valid && in_smp.ready;
  assign last         = (cnt_r == CNT_W'(SAMPLES_PER_EPOCH - 1));
  assign warm_done    = (warm_r >= WARM_W'(WARMUP_EPOCHS));
  assign sum_new      = acc_r + in_smp.accel_x + in_smp.accel_y + in_smp.accel_z;

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      e[i] = {{(TOTAL_W - DATA_W){hist_r[i][DATA_W-1]}}, hist_r[i]};
    end
    pair_out  = e[0] + e[4];
    pair_in   = e[1] + e[3];
    total     = pair_out + (pair_in <<< 2) + pair_in
              + (e[2] <<< 4) + (e[2] <<< 3) + e[2];
    total_abs = total[TOTAL_W-1] ? -total : total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      warm_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          acc_r <= '0;
          cnt_r <= '0;
          if (!warm_done) begin
            warm_r <= warm_r + WARM_W'(1);
          end
        end else begin
          acc_r <= sum_new;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      s1_v_r <= (s1_v_r && !ld2) || (accept && last && warm_done);
      if (ld2) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // history and total carry no reset
  always_ff @(posedge clk) begin
    if (accept && last) begin
      hist_r[0] <= sum_new;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    if (ld2) begin
      s2_tok_r.epoch_sum <= hist_r[0];
      s2_tok_r.neg       <= total[TOTAL_W-1];
      s2_tok_r.mag       <= total_abs[MAG_W-1:0];
    end
  end

  assign tok_valid = s2_v_r;
  assign tok       = s2_tok_r;

endmodule

// ===== rtl/actss_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actss_score
// divide by 25, saturate, threshold compare and sleep minute count
// ----------------------------------------------------------------------------
module actss_score import actss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tok_valid,
  output logic                 tok_ready,
  input  actss_token_t         tok,
  input  logic signed [DATA_W-1:0] threshold,
  actss_result_if.source       out_res
);

  logic              s3_v_r;
  logic              s3_neg_r;
  logic [DATA_W-1:0] s3_q_r;
  logic [DATA_W-1:0] s3_sum_r;
  logic              out_v_r;
  logic [DATA_W-1:0] sum_r;
  logic [DATA_W-1:0] act_r;
  logic              below_r;
  logic [DATA_W-1:0] mins_r;

  logic                      ld_out;
  logic                      ld3;
  logic [MAG_W+RECIP_W-1:0]  prod;
  logic [DATA_W-1:0]         act;
  logic                      below;

  assign ld_out    = !out_v_r || out_res.ready;
  assign ld3       = !s3_v_r || ld_out;
  assign tok_ready = ld3;

  assign prod = (MAG_W + RECIP_W)'(tok.mag) * (MAG_W + RECIP_W)'(RECIP);

  // clamp the signed quotient to the int16 range
  always_comb begin
    if (s3_neg_r) begin
      act = (s3_q_r > NEG_LIMIT) ? NEG_LIMIT : (~s3_q_r + DATA_W'(1));
    end else begin
      act = (s3_q_r > POS_LIMIT) ? POS_LIMIT : s3_q_r;
    end
    below = $signed(act) < threshold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mins_r  <= '0;
    end else begin
      if (ld3) begin
        s3_v_r <= tok_valid;
      end
      if (ld_out) begin
        out_v_r <= s3_v_r;
        if (s3_v_r && below && (mins_r != COUNT_MAX)) begin
          mins_r <= mins_r + DATA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_neg_r <= tok.neg;
      s3_q_r   <= prod[RECIP_SHIFT +: DATA_W];
      s3_sum_r <= tok.epoch_sum;
    end
    if (ld_out) begin
      sum_r   <= s3_sum_r;
      act_r   <= act;
      below_r <= below;
    end
  end

  // count is already bumped by the time the beat is shown
  logic [DATA_W-1:0] mins_show;
  assign mins_show = mins_r;

  assign out_res.valid           = out_v_r;
  assign out_res.epoch_sum       = sum_r;
  assign out_res.activity        = act_r;
  assign out_res.below_threshold = below_r;
  assign out_res.sleep_minutes   = mins_show;

endmodule

// ===== rtl/actigraphy_sleep_scorer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actigraphy_sleep_scorer_core
// scores accelerometer epochs as asleep or awake and counts sleep minutes
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  in_smp    sink       accel_x, accel_y, accel_z
//  out_res   source     epoch_sum, activity, below_threshold, sleep_minutes
//  cfg_wr    sink       sleep_threshold (always ready)
//
//  one sample beat per cycle while in_smp is ready; a scored epoch's result beat
//  leaves after its last sample through epoch, total, divide and output registers
//  rst_n clears counters, accumulator, threshold and sleep count; history is not
//  cleared, warm-up writes all of it before the first score
//  a stalled result backs up the pipeline; in_smp only stalls when a scored
//  epoch cannot move on
`include "assert_macros.svh"

module actigraphy_sleep_scorer_core import actss_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  actss_sample_if.sink    in_smp,
  actss_result_if.source  out_res,
  actss_cfg_if.sink       cfg_wr
);

  logic signed [DATA_W-1:0] thr_r;
  logic                     tok_valid;
  logic                     tok_ready;
  actss_token_t             tok;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr.valid) begin
      thr_r <= cfg_wr.sleep_threshold;
    end
  end

  actss_epoch u_epoch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_smp    (in_smp),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  actss_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .threshold (thr_r),
    .out_res   (out_res)
  );

  // a sleeping epoch has always been counted
  `ASSERT_SAME(a_below_counted, out_res.valid && out_res.below_threshold,
               out_res.sleep_minutes != '0)
  // flag agrees with the threshold, which the user must change only while idle; the block does not enforce it
  `ASSERT_SAME(a_below_matches, out_res.valid,
               out_res.below_threshold == ($signed(out_res.activity) < thr_r))
  // samples are only held back by a blocked result
  `ASSERT_SAME(a_stall_source, !in_smp.ready, out_res.valid && !out_res.ready)

endmodule
